[hdl/ve3d_pkg.sv]
// Shared constants, register indexes and control types of the 3-D voxel erosion block.
package ve3d_pkg;

	localparam int VALUE_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ZS_W       = 13;
	localparam int CZ_W       = 12;
	localparam int MAX_Z      = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_X_SIZE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRAY_LEVEL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_SELECT = 3'd4;

	localparam int RST_X_SIZE     = 128;
	localparam int RST_Y_SIZE     = 128;
	localparam int RST_Z_SIZE     = 128;
	localparam int RST_GRAY_LEVEL = 256;

	typedef struct packed {
		logic adv;
		logic clr;
	} win_ctl_t;

endpackage

[hdl/ve3d_intf.sv]
// Handshake interfaces for the voxel, result and configuration channels.
interface ve3d_vox_if;
	logic                             valid;
	logic                             ready;
	logic [ve3d_pkg::VALUE_W-1:0]     voxel_value;
	logic                             is_pad;
	modport source(output valid, voxel_value, is_pad, input ready);
	modport sink(input valid, voxel_value, is_pad, output ready);
endinterface

interface ve3d_res_if;
	logic                             valid;
	logic                             ready;
	logic [ve3d_pkg::VALUE_W-1:0]     out_value;
	logic                             last_out;
	modport source(output valid, out_value, last_out, input ready);
	modport sink(input valid, out_value, last_out, output ready);
endinterface

interface ve3d_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ve3d_pkg::CFG_IDX_W-1:0]   index;
	logic [ve3d_pkg::CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/voxel_erosion_3d.sv]
// Top level of the streaming 3-D erosion block with configuration, counters and output stage.
// A voxel's result enters stage s1 with the request that completes its window, which is
// x_size*y_size + y_size + 1 requests after the voxel's own request, and is then registered
// in the output stage. Throughput is one request per cycle while the output is not stalled:
// each line-buffer RAM does one read and one write per request. Reset restores the register
// defaults and empties the output stages; the line-buffer memories are not cleared.
module voxel_erosion_3d #(
	parameter int MAX_X      = 128,
	parameter int MAX_Y      = 128,
	parameter int VOXEL_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	ve3d_vox_if.sink       vox,
	ve3d_res_if.source     res,
	ve3d_cfg_if.sink       cfg
);

	localparam int XW     = $clog2(MAX_X + 1);
	localparam int YW     = $clog2(MAX_Y + 1);
	localparam int PW     = XW + YW;
	localparam int DMAX   = MAX_X * MAX_Y + MAX_Y + 1;
	localparam int DW     = $clog2(DMAX + 2);
	localparam int RDEPTH = MAX_Y - 1;
	localparam int RLW    = $clog2(RDEPTH + 1);
	localparam int PDEPTH = (MAX_X - 2) * MAX_Y - 1;
	localparam int PLW    = $clog2(PDEPTH + 1);
	localparam int ZW     = ve3d_pkg::ZS_W;
	localparam int CZW    = ve3d_pkg::CZ_W;
	localparam int VW     = ve3d_pkg::VALUE_W;

	localparam int RST_XS    = (ve3d_pkg::RST_X_SIZE > MAX_X) ? MAX_X : ve3d_pkg::RST_X_SIZE;
	localparam int RST_YS    = (ve3d_pkg::RST_Y_SIZE > MAX_Y) ? MAX_Y : ve3d_pkg::RST_Y_SIZE;
	localparam int RST_ZS    = ve3d_pkg::RST_Z_SIZE;
	localparam int RST_PLANE = RST_XS * RST_YS;
	localparam int RST_DELAY = RST_PLANE + RST_YS + 1;
	localparam int RST_PLEN  = RST_PLANE - 2 * RST_YS - 1;
	localparam int RST_RLEN  = RST_YS - 1;
	localparam int RST_FG    = ve3d_pkg::RST_GRAY_LEVEL - 1;

	// Configuration and derived geometry.
	logic [XW-1:0]   xs_q;
	logic [YW-1:0]   ys_q;
	logic [ZW-1:0]   zs_q;
	logic [DW-1:0]   delay_q;
	logic [PLW-1:0]  plen_q;
	logic [RLW-1:0]  rlen_q;
	logic [VW-1:0]   fg_q;
	logic            mode_q;

	logic            cfg_acc;
	logic [7:0]      x_raw;
	logic [7:0]      y_raw;
	logic [ZW-1:0]   z_raw;
	logic [XW-1:0]   xs_w;
	logic [YW-1:0]   ys_w;
	logic [ZW-1:0]   zs_w;
	logic [XW-1:0]   xs_n;
	logic [YW-1:0]   ys_n;
	logic [PW-1:0]   plane_n;

	// Volume tracking.
	logic [DW-1:0]   items_seen_q;
	logic [XW-1:0]   cx_q;
	logic [YW-1:0]   cy_q;
	logic [CZW-1:0]  cz_q;

	logic            acc;
	logic            adv;
	logic            emit;
	logic            row_end;
	logic            col_end;
	logic            pln_end;
	logic            last_now;
	logic            interior;
	logic [VOXEL_BITS-1:0] pix;

	// Result stages.
	logic            valid_s1;
	logic            interior_s1;
	logic            last_s1;
	logic            s1_go;
	logic            out_valid_q;
	logic [VW-1:0]   out_value_q;
	logic            out_last_q;

	logic [2:0][2:0][2:0][VOXEL_BITS-1:0] taps;
	logic [VOXEL_BITS-1:0] cval;
	logic            any_zero;
	logic            eroded;
	logic [VW-1:0]   res_value;

	ve3d_pkg::win_ctl_t win_ctl;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;

	assign x_raw = cfg.data[7:0];
	assign y_raw = cfg.data[7:0];
	assign z_raw = cfg.data[ZW-1:0];

	always_comb begin
		if (x_raw == '0) begin
			xs_w = XW'(1);
		end else if (x_raw > MAX_X) begin
			xs_w = XW'(MAX_X);
		end else begin
			xs_w = XW'(x_raw);
		end

		if (y_raw == '0) begin
			ys_w = YW'(1);
		end else if (y_raw > MAX_Y) begin
			ys_w = YW'(MAX_Y);
		end else begin
			ys_w = YW'(y_raw);
		end

		if (z_raw == '0) begin
			zs_w = ZW'(1);
		end else if (z_raw > ve3d_pkg::MAX_Z) begin
			zs_w = ZW'(ve3d_pkg::MAX_Z);
		end else begin
			zs_w = z_raw;
		end

		xs_n    = (cfg.index == ve3d_pkg::REG_X_SIZE) ? xs_w : xs_q;
		ys_n    = (cfg.index == ve3d_pkg::REG_Y_SIZE) ? ys_w : ys_q;
		plane_n = PW'(xs_n) * PW'(ys_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xs_q    <= XW'(RST_XS);
			ys_q    <= YW'(RST_YS);
			zs_q    <= ZW'(RST_ZS);
			delay_q <= DW'(RST_DELAY);
			plen_q  <= PLW'(RST_PLEN);
			rlen_q  <= RLW'(RST_RLEN);
			fg_q    <= VW'(RST_FG);
			mode_q  <= 1'b0;
		end else if (cfg_acc) begin
			xs_q    <= xs_n;
			ys_q    <= ys_n;
			delay_q <= DW'(plane_n) + DW'(ys_n) + DW'(1);
			rlen_q  <= RLW'(ys_n - YW'(1));
			if (xs_n >= XW'(3)) begin
				plen_q <= PLW'(plane_n - (PW'(ys_n) << 1) - PW'(1));
			end else begin
				plen_q <= '0;
			end
			case (cfg.index)
				ve3d_pkg::REG_Z_SIZE: begin
					zs_q <= zs_w;
				end
				ve3d_pkg::REG_GRAY_LEVEL: begin
					fg_q <= cfg.data[VW-1:0] - VW'(1);
				end
				ve3d_pkg::REG_MODE_SELECT: begin
					mode_q <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Request handling.
	assign vox.ready = !valid_s1 || !out_valid_q || res.ready;
	assign acc       = vox.valid && vox.ready;
	assign adv       = acc && !(vox.is_pad && items_seen_q == '0);
	assign emit      = adv && (items_seen_q >= delay_q);
	assign pix       = vox.is_pad ? '0 : vox.voxel_value[VOXEL_BITS-1:0];

	assign row_end  = (YW+1)'(cy_q) + (YW+1)'(1) >= (YW+1)'(ys_q);
	assign col_end  = (XW+1)'(cx_q) + (XW+1)'(1) >= (XW+1)'(xs_q);
	assign pln_end  = (ZW+1)'(cz_q) + (ZW+1)'(1) >= (ZW+1)'(zs_q);
	assign last_now = row_end && col_end && pln_end;

	assign interior = (cx_q != '0) && ((XW+1)'(cx_q) + (XW+1)'(2) <= (XW+1)'(xs_q)) &&
		(cy_q != '0) && ((YW+1)'(cy_q) + (YW+1)'(2) <= (YW+1)'(ys_q)) &&
		(cz_q != '0) && ((ZW+1)'(cz_q) + (ZW+1)'(2) <= (ZW+1)'(zs_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_seen_q <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			cz_q         <= '0;
		end else if (cfg_acc || (emit && last_now)) begin
			items_seen_q <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			cz_q         <= '0;
		end else begin
			if (adv && items_seen_q <= delay_q) begin
				items_seen_q <= items_seen_q + DW'(1);
			end
			if (emit) begin
				if (row_end) begin
					cy_q <= '0;
					if (col_end) begin
						cx_q <= '0;
						cz_q <= cz_q + CZW'(1);
					end else begin
						cx_q <= cx_q + XW'(1);
					end
				end else begin
					cy_q <= cy_q + YW'(1);
				end
			end
		end
	end

	assign win_ctl.adv = adv;
	assign win_ctl.clr = cfg_acc;

	ve3d_window #(
		.MAX_X(MAX_X),
		.MAX_Y(MAX_Y),
		.VB   (VOXEL_BITS)
	) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (win_ctl),
		.pix   (pix),
		.rlen  (rlen_q),
		.plen  (plen_q),
		.taps  (taps)
	);

	// With fewer than three rows per plane the plane buffer collapses, so the
	// center voxel sits at an earlier tap.
	always_comb begin
		if (xs_q >= XW'(3)) begin
			cval = taps[1][1][1];
		end else if (xs_q == XW'(2)) begin
			cval = taps[1][1][0];
		end else begin
			cval = taps[1][0][0];
		end

		any_zero = 1'b0;
		for (int g = 0; g < 3; g++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (!(g == 1 && r == 1 && c == 1) && taps[g][r][c] == '0) begin
						any_zero = 1'b1;
					end
				end
			end
		end

		eroded = interior_s1 && (VW'(cval) == fg_q) && any_zero;

		if (mode_q) begin
			res_value = eroded ? fg_q : '0;
		end else begin
			res_value = eroded ? '0 : VW'(cval);
		end
	end

	assign s1_go = valid_s1 && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			interior_s1 <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_s1    <= 1'b1;
				interior_s1 <= interior;
				last_s1     <= last_now;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_value_q <= res_value;
			out_last_q  <= last_s1;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.out_value = out_value_q;
	assign res.last_out  = out_last_q;

endmodule

[hdl/ve3d_ram.sv]
// Generic single-clock RAM with one write port and one registered read-first read port.
module ve3d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/ve3d_linebuf.sv]
// Multi-lane delay line of programmable length built on one RAM with a shared pointer.
module ve3d_linebuf #(
	parameter int LANES = 2,
	parameter int VB    = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH),
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ve3d_pkg::win_ctl_t              ctl,
	input  logic [LW-1:0]                   len,
	input  logic [LANES-1:0][VB-1:0]        din,
	output logic [LANES-1:0][VB-1:0]        dout
);

	logic [AW-1:0]              ptr_q;
	logic [LANES-1:0][VB-1:0]   byp_q;
	logic [LANES*VB-1:0]        rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctl.clr) begin
			ptr_q <= '0;
		end else if (ctl.adv) begin
			if (LW'(ptr_q) + LW'(1) >= len) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// A length of zero still delays by one request through the bypass register.
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			byp_q <= din;
		end
	end

	ve3d_ram #(
		.WIDTH(LANES * VB),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.adv),
		.waddr(ptr_q),
		.wdata(din),
		.re   (ctl.adv),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	assign dout = (len == '0) ? byp_q : rdata;

endmodule

[hdl/ve3d_window.sv]
// Three-by-three-by-three voxel window built from row and plane line buffers.
module ve3d_window #(
	parameter int MAX_X = 128,
	parameter int MAX_Y = 128,
	parameter int VB    = 16,
	localparam int RDEPTH = MAX_Y - 1,
	localparam int RLW    = $clog2(RDEPTH + 1),
	localparam int PDEPTH = (MAX_X - 2) * MAX_Y - 1,
	localparam int PLW    = $clog2(PDEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ve3d_pkg::win_ctl_t                 ctl,
	input  logic [VB-1:0]                      pix,
	input  logic [RLW-1:0]                     rlen,
	input  logic [PLW-1:0]                     plen,
	output logic [2:0][2:0][2:0][VB-1:0]       taps
);

	logic [VB-1:0]              head_q;
	logic [2:0][2:0][VB-1:0]    head;
	logic [2:0][2:0][VB-1:0]    sh1_q;
	logic [2:0][2:0][VB-1:0]    sh2_q;
	logic [5:0][VB-1:0]         row_din;
	logic [5:0][VB-1:0]         row_dout;
	logic [1:0][VB-1:0]         pln_din;
	logic [1:0][VB-1:0]         pln_dout;

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			head_q <= pix;
			sh1_q  <= head;
			sh2_q  <= sh1_q;
		end
	end

	// Row heads sit g planes and r rows behind the newest voxel.
	always_comb begin
		head[0][0] = head_q;
		head[0][1] = row_dout[0];
		head[0][2] = row_dout[1];
		head[1][0] = pln_dout[0];
		head[1][1] = row_dout[2];
		head[1][2] = row_dout[3];
		head[2][0] = pln_dout[1];
		head[2][1] = row_dout[4];
		head[2][2] = row_dout[5];

		row_din[0] = head[0][0];
		row_din[1] = head[0][1];
		row_din[2] = head[1][0];
		row_din[3] = head[1][1];
		row_din[4] = head[2][0];
		row_din[5] = head[2][1];
		pln_din[0] = head[0][2];
		pln_din[1] = head[1][2];
	end

	ve3d_linebuf #(
		.LANES(6),
		.VB   (VB),
		.DEPTH(RDEPTH)
	) u_rows (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.len   (rlen),
		.din   (row_din),
		.dout  (row_dout)
	);

	ve3d_linebuf #(
		.LANES(2),
		.VB   (VB),
		.DEPTH(PDEPTH)
	) u_planes (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.len   (plen),
		.din   (pln_din),
		.dout  (pln_dout)
	);

	always_comb begin
		for (int g = 0; g < 3; g++) begin
			for (int r = 0; r < 3; r++) begin
				taps[g][r][0] = head[g][r];
				taps[g][r][1] = sh1_q[g][r];
				taps[g][r][2] = sh2_q[g][r];
			end
		end
	end

endmodule

[bench/voxel_erosion_3d_tb.sv]
// Self-checking testbench for voxel_erosion_3d: random volumes, size and mode sweeps, stalls.
module voxel_erosion_3d_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_X      = 128;
	localparam int MAX_Y      = 128;
	localparam int VOXEL_BITS = 16;
	localparam int VW         = ve3d_pkg::VALUE_W;
	localparam int ZW         = ve3d_pkg::ZS_W;
	localparam int WIN_DEPTH  = 2 * MAX_X * MAX_Y + 2 * MAX_Y + 3;
	localparam logic [ve3d_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 400;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 8;

	typedef struct {
		logic [VW-1:0] value;
		logic          pad;
	} vox_item_t;

	typedef struct {
		logic [VW-1:0] value;
		logic          last;
	} voxel_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ve3d_vox_if vox();
	ve3d_res_if res();
	ve3d_cfg_if cfg();

	voxel_erosion_3d #(
		.MAX_X(MAX_X),
		.MAX_Y(MAX_Y),
		.VOXEL_BITS(VOXEL_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.vox(vox),
		.res(res),
		.cfg(cfg)
	);

	always #5 clk = ~clk;

	// Erosion state tracked alongside the block.
	logic [VW-1:0]      win_mem [WIN_DEPTH];
	int unsigned        wr_slot, ctr_y, ctr_x, ctr_z, fill_cnt;
	logic [7:0]         reg_xs, reg_ys;
	logic [ZW-1:0]      reg_zs;
	logic [15:0]        reg_gray;
	logic               reg_mode;

	vox_item_t     vox_pending[$];
	voxel_result_t eroded_expect[$];
	vox_item_t     next_item;
	voxel_result_t got_exp;

	bit          calm;
	int unsigned src_gap, sink_wait;
	int unsigned hold_req, hold_ack;
	int unsigned items_sent, requests_taken, results_seen, reg_writes, volumes, errors;
	int unsigned hold_mark;

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void restart_volume();
		wr_slot  = 0;
		ctr_y    = 0;
		ctr_x    = 0;
		ctr_z    = 0;
		fill_cnt = 0;
	endfunction

	function automatic void predict_erosion(logic [VW-1:0] value, logic pad);
		int unsigned   xs, ys, zs, plane, span, newest;
		int            base, slot;
		logic [VW-1:0] fg, v, centre, outv;
		logic          interior, eroded, last;
		xs     = clamp_size(reg_xs, MAX_X);
		ys     = clamp_size(reg_ys, MAX_Y);
		zs     = clamp_size(reg_zs, ve3d_pkg::MAX_Z);
		plane  = xs * ys;
		span   = plane + ys + 1;
		fg     = reg_gray - 16'd1;
		v      = pad ? '0 : value;
		eroded = 1'b0;
		if (pad && fill_cnt == 0) return;
		newest          = wr_slot;
		win_mem[newest] = v;
		wr_slot         = (wr_slot + 1) % WIN_DEPTH;
		if (fill_cnt <= span) fill_cnt++;
		if (fill_cnt <= span) return;
		base     = int'(newest) + 2 * WIN_DEPTH - int'(span);
		centre   = win_mem[base % WIN_DEPTH];
		interior = ctr_x >= 1 && ctr_x + 2 <= xs && ctr_y >= 1 && ctr_y + 2 <= ys &&
			ctr_z >= 1 && ctr_z + 2 <= zs;
		if (interior && centre == fg) begin
			for (int dz = -1; dz <= 1; dz++) begin
				for (int dx = -1; dx <= 1; dx++) begin
					for (int dy = -1; dy <= 1; dy++) begin
						slot = base + dz * int'(plane) + dx * int'(ys) + dy;
						if (!(dz == 0 && dx == 0 && dy == 0) && win_mem[slot % WIN_DEPTH] == '0)
							eroded = 1'b1;
					end
				end
			end
		end
		if (reg_mode)
			outv = eroded ? fg : '0;
		else
			outv = eroded ? '0 : centre;
		last = ctr_y + 1 >= ys && ctr_x + 1 >= xs && ctr_z + 1 >= zs;
		eroded_expect.push_back('{value: outv, last: last});
		if (last) begin
			restart_volume();
		end else begin
			ctr_y++;
			if (ctr_y >= ys) begin
				ctr_y = 0;
				ctr_x++;
				if (ctr_x >= xs) begin
					ctr_x = 0;
					ctr_z++;
				end
			end
		end
	endfunction

	// Voxel driver: the model is advanced on every accepted request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (vox.valid && vox.ready) begin
				predict_erosion(vox.voxel_value, vox.is_pad);
				requests_taken++;
			end
			if (!vox.valid || vox.ready) begin
				if (src_gap > 0) begin
					vox.valid <= 1'b0;
					src_gap--;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					vox.valid <= 1'b0;
					src_gap = $urandom_range(0, 16);
				end else if (vox_pending.size() > 0) begin
					next_item = vox_pending.pop_front();
					vox.valid       <= 1'b1;
					vox.voxel_value <= next_item.value;
					vox.is_pad      <= next_item.pad;
				end else begin
					vox.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready) begin
				results_seen++;
				if (eroded_expect.size() == 0) begin
					$error("unexpected result: out_value %h last_out %b", res.out_value,
						res.last_out);
					errors++;
				end else begin
					got_exp = eroded_expect.pop_front();
					if (res.out_value !== got_exp.value) begin
						$error("out_value: expected %h, actual %h", got_exp.value, res.out_value);
						errors++;
					end
					if (res.last_out !== got_exp.last) begin
						$error("last_out: expected %b, actual %b", got_exp.last, res.last_out);
						errors++;
					end
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack  = hold_req;
				sink_wait = LONG_HOLD;
				res.ready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				res.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				sink_wait = $urandom_range(0, 16);
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic queue_item(input logic [VW-1:0] value, input logic pad);
		vox_pending.push_back('{value: value, pad: pad});
		items_sent++;
	endtask

	task automatic drain();
		forever begin
			@(negedge clk);
			if (vox_pending.size() == 0 && !vox.valid && eroded_expect.size() == 0) break;
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ve3d_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			ve3d_pkg::REG_X_SIZE:      reg_xs = value[7:0];
			ve3d_pkg::REG_Y_SIZE:      reg_ys = value[7:0];
			ve3d_pkg::REG_Z_SIZE:      reg_zs = value[ZW-1:0];
			ve3d_pkg::REG_GRAY_LEVEL:  reg_gray = value;
			ve3d_pkg::REG_MODE_SELECT: reg_mode = value[0];
			default: ;
		endcase
		restart_volume();
		reg_writes++;
	endtask

	task automatic configure(input int unsigned xs, ys, zs, gray, input bit mode,
		input bit spare);
		drain();
		@(posedge clk);
		if (spare) write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(ve3d_pkg::REG_X_SIZE, 16'(xs));
		write_reg(ve3d_pkg::REG_Y_SIZE, 16'(ys));
		write_reg(ve3d_pkg::REG_Z_SIZE, 16'(zs));
		write_reg(ve3d_pkg::REG_GRAY_LEVEL, 16'(gray));
		write_reg(ve3d_pkg::REG_MODE_SELECT, 16'(mode));
		cfg.valid <= 1'b0;
	endtask

	// Queues one volume at the current sizes, then the flush pads; truncate stops at half.
	task automatic feed_volume(input bit pause_mid, input bit truncate);
		int unsigned   xs, ys, zs, total, span, pick;
		logic [VW-1:0] fg;
		xs    = clamp_size(reg_xs, MAX_X);
		ys    = clamp_size(reg_ys, MAX_Y);
		zs    = clamp_size(reg_zs, ve3d_pkg::MAX_Z);
		total = xs * ys * zs;
		span  = xs * ys + ys + 1;
		fg    = reg_gray - 16'd1;
		volumes++;
		for (int unsigned i = 0; i < total; i++) begin
			if (i == total / 2 && pause_mid) drain();
			if (i == total / 2 && truncate) return;
			pick = $urandom_range(0, 99);
			if (pick < 2)
				queue_item(16'($urandom), 1'b1);
			else if (pick < 70)
				queue_item(fg, 1'b0);
			else if (pick < 85)
				queue_item('0, 1'b0);
			else
				queue_item(16'($urandom), 1'b0);
		end
		repeat (span) queue_item(16'($urandom), 1'b1);
	endtask

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned gray_pick, gray;
		arst_n          = 1'b0;
		vox.valid       = 1'b0;
		vox.voxel_value = '0;
		vox.is_pad      = 1'b0;
		res.ready       = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = '0;
		cfg.data        = '0;
		reg_xs   = 8'(ve3d_pkg::RST_X_SIZE);
		reg_ys   = 8'(ve3d_pkg::RST_Y_SIZE);
		reg_zs   = ZW'(ve3d_pkg::RST_Z_SIZE);
		reg_gray = 16'(ve3d_pkg::RST_GRAY_LEVEL);
		reg_mode = 1'b0;
		restart_volume();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle pads, single-voxel volumes, zero sizes and gray level zero.
		queue_item(16'hFFFF, 1'b1);
		queue_item(16'h0000, 1'b1);
		configure(0, 0, 0, 0, 0, 1);
		queue_item(16'hFFFF, 1'b0);
		repeat (3) queue_item(16'h0000, 1'b1);
		queue_item(16'hFFFF, 1'b1);
		queue_item(16'h0000, 1'b0);
		repeat (3) queue_item(16'hFFFF, 1'b1);
		configure(0, 0, 0, 0, 1, 0);
		queue_item(16'hFFFF, 1'b0);
		repeat (3) queue_item(16'h5A5A, 1'b1);
		configure(3, 3, 3, 1, 1, 0);
		feed_volume(0, 0);
		configure(3, 3, 3, 1, 0, 0);
		feed_volume(0, 0);

		// Size extremes; the receiver holds off long enough to back up the input.
		configure(255, 1, 1, 65535, 0, 0);
		hold_mark = results_seen;
		feed_volume(0, 0);
		wait (results_seen >= hold_mark + 40);
		hold_req++;
		configure(1, 200, 1, 256, 1, 0);
		feed_volume(0, 0);
		configure(1, 1, 9, 2, 0, 0);
		feed_volume(0, 0);
		configure(128, 1, 1, 256, 0, 0);
		feed_volume(0, 0);

		// Sender stops halfway until every result is in; then an abandoned volume.
		configure(4, 4, 4, 256, 0, 0);
		feed_volume(1, 0);
		configure(4, 4, 4, 256, 1, 0);
		feed_volume(0, 1);

		hold_mark = items_sent;
		while (items_sent < hold_mark + RANDOM_ITEMS) begin
			gray_pick = $urandom_range(0, 4);
			case (gray_pick)
				0: gray = $urandom_range(0, 65535);
				1: gray = 256;
				2: gray = 1;
				3: gray = 0;
				default: gray = 65535;
			endcase
			if (items_sent > hold_mark + RANDOM_ITEMS - 150) calm = 1'b1;
			configure($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6), gray,
				$urandom_range(0, 1), 0);
			feed_volume(0, $urandom_range(0, 9) == 0);
			repeat ($urandom_range(0, 2)) queue_item(16'($urandom), 1'b1);
		end
		drain();

		if (eroded_expect.size() != 0) errors++;
		$display("Covered %0d voxel requests in %0d volumes with %0d register writes.",
			requests_taken, volumes, reg_writes);
		$display("Checked %0d results across erode and boundary modes.", results_seen);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
